/* src/cumulative_l1_weight_update_top_defines.svh */
// Assertion macros used by the checker file of the cumulative L1 weight update block.
// Depends on nothing; include by bare file name.
`ifndef CUMULATIVE_L1_WEIGHT_UPDATE_TOP_DEFINES_SVH
`define CUMULATIVE_L1_WEIGHT_UPDATE_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high
`define CLWU_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Concurrent assertion that also holds across reset
`define CLWU_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

/* src/clwu_pkg.sv */
// Shared types, constants and saturation helper for the cumulative L1 weight update block.
// No dependencies.
`default_nettype none

package clwu_pkg;

  // Table depth and address width
  localparam int NUM_FEATURES = 1024;
  localparam int ADDR_W       = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  // Field widths
  localparam int IDX_W  = 10;
  localparam int Q_W    = 32;
  localparam int LR_W   = 24;
  localparam int PEN_W  = 31;
  localparam int FRAC_W = 24;
  localparam int PROD_W = 34;
  localparam int WIDE_W = 36;

  // Saturation bounds in the wide domain
  localparam logic signed [WIDE_W-1:0] Q_MAX_W = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] Q_MIN_W = -WIDE_W'(64'sd2147483648);

  // One write to both tables
  typedef struct packed {
    logic                    en;
    logic [ADDR_W-1:0]       addr;
    logic signed [Q_W-1:0]   weight;
    logic signed [Q_W-1:0]   penalty;
  } wr_req_t;

  // Sign-extend a Q8.24 word into the wide domain
  function automatic logic signed [WIDE_W-1:0] sx_q(input logic signed [Q_W-1:0] v);
    sx_q = {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
  endfunction

  // Clamp a wide value to the 32-bit signed range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    if (v > Q_MAX_W) begin
      sat_q = Q_MAX_W[Q_W-1:0];
    end else if (v < Q_MIN_W) begin
      sat_q = Q_MIN_W[Q_W-1:0];
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* src/clwu_store.sv */
// Weight and applied-penalty tables with registered read and a clearing sweep after reset.
// Depends on clwu_pkg.
`default_nettype none

module clwu_store import clwu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  input  wire wr_req_t               wr,
  output logic signed [Q_W-1:0]      rd_weight,
  output logic signed [Q_W-1:0]      rd_penalty,
  output logic                       clearing
);

  logic signed [Q_W-1:0] weight_mem  [NUM_FEATURES];
  logic signed [Q_W-1:0] penalty_mem [NUM_FEATURES];
  logic [ADDR_W-1:0]     clr_addr;

  // Sweep every entry to zero after reset, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(NUM_FEATURES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Write port: clearing sweep or pipeline write-back; read data registered
  always_ff @(posedge clk) begin
    if (clearing) begin
      weight_mem[clr_addr]  <= '0;
      penalty_mem[clr_addr] <= '0;
    end else if (wr.en) begin
      weight_mem[wr.addr]  <= wr.weight;
      penalty_mem[wr.addr] <= wr.penalty;
    end
    rd_weight  <= weight_mem[rd_addr];
    rd_penalty <= penalty_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/cumulative_l1_weight_update_top.sv */
// Top level of the cumulative L1 weight update block: three-stage pipeline around the tables.
// Depends on clwu_pkg and clwu_store.
`default_nettype none

// After reset the block sweeps both tables to zero (one entry per cycle through the
// table write port) and holds busy high meanwhile. From then on busy stays low and one
// transaction is taken per cycle: the product is registered at the accepting edge
// together with the table read, the saturated sum is registered in stage 2 and clipped
// there, and the new weight and applied penalty are registered onto the result ports
// with done high, for one cycle only. The receiver has no way to hold a result off;
// it must take each one in the cycle done is high. Updates of the same feature in
// consecutive cycles are forwarded inside the pipeline, so every transaction sees the
// result of the one before it.
module cumulative_l1_weight_update_top import clwu_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [IDX_W-1:0]        feature_index,
  input  wire logic signed [Q_W-1:0]   gradient,
  input  wire logic [LR_W-1:0]         step_size,
  input  wire logic [PEN_W-1:0]        total_penalty,
  output logic                         done,
  output logic signed [Q_W-1:0]        new_weight,
  output logic signed [Q_W-1:0]        applied_penalty
);

  localparam logic signed [56:0] ROUND_HALF = 57'sd1 <<< (FRAC_W - 1);

  logic                    accept;
  logic                    clearing;
  logic [ADDR_W-1:0]       in_addr;
  logic                    in_range;
  logic signed [56:0]      g_ext;
  logic signed [56:0]      lr_ext;
  logic signed [56:0]      mul_full;
  logic signed [56:0]      mul_round;
  logic signed [Q_W-1:0]   rd_weight;
  logic signed [Q_W-1:0]   rd_penalty;
  wr_req_t                 wr;

  // Stage 1 registers
  logic                    s1_valid;
  logic                    s1_in_range;
  logic [ADDR_W-1:0]       s1_addr;
  logic signed [PROD_W-1:0] s1_prod;
  logic [PEN_W-1:0]        s1_u;

  // Stage 2 registers
  logic                    s2_valid;
  logic                    s2_in_range;
  logic [ADDR_W-1:0]       s2_addr;
  logic signed [Q_W-1:0]   s2_z;
  logic signed [Q_W-1:0]   s2_q;
  logic [PEN_W-1:0]        s2_u;

  // Write-back registers
  logic                    wb_wr;
  logic [ADDR_W-1:0]       wb_addr;

  logic signed [Q_W-1:0]   w_fwd;
  logic signed [Q_W-1:0]   q_fwd;
  logic signed [WIDE_W-1:0] z_sum;
  logic signed [Q_W-1:0]   z_next;
  logic signed [WIDE_W-1:0] z_w;
  logic signed [WIDE_W-1:0] q_w;
  logic signed [WIDE_W-1:0] u_w;
  logic signed [WIDE_W-1:0] clip_raw;
  logic signed [Q_W-1:0]   nw_next;
  logic signed [Q_W-1:0]   nq_next;

  assign busy     = clearing;
  assign accept   = start && !busy;
  assign in_addr  = ADDR_W'(feature_index);
  assign in_range = 32'(feature_index) < NUM_FEATURES;

  // Round the gradient step to nearest, ties upward
  assign g_ext     = {{(57-Q_W){gradient[Q_W-1]}}, gradient};
  assign lr_ext    = {{(57-LR_W){1'b0}}, step_size};
  assign mul_full  = g_ext * lr_ext;
  assign mul_round = (mul_full + ROUND_HALF) >>> FRAC_W;

  clwu_store u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (in_addr),
    .wr         (wr),
    .rd_weight  (rd_weight),
    .rd_penalty (rd_penalty),
    .clearing   (clearing)
  );

  // Stage 1: capture the transaction and the rounded product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_in_range <= in_range;
    s1_addr     <= in_addr;
    s1_prod     <= mul_round[PROD_W-1:0];
    s1_u        <= total_penalty;
  end

  // Forward the newest write of the same feature over the table read
  always_comb begin
    if (!s1_in_range) begin
      w_fwd = '0;
      q_fwd = '0;
    end else if (s2_valid && s2_in_range && (s2_addr == s1_addr)) begin
      w_fwd = nw_next;
      q_fwd = nq_next;
    end else if (wb_wr && (wb_addr == s1_addr)) begin
      w_fwd = new_weight;
      q_fwd = applied_penalty;
    end else begin
      w_fwd = rd_weight;
      q_fwd = rd_penalty;
    end
  end

  // Saturated sum of weight and step
  assign z_sum  = sx_q(w_fwd) + {{(WIDE_W-PROD_W){s1_prod[PROD_W-1]}}, s1_prod};
  assign z_next = sat_q(z_sum);

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_in_range <= s1_in_range;
    s2_addr     <= s1_addr;
    s2_z        <= z_next;
    s2_q        <= q_fwd;
    s2_u        <= s1_u;
  end

  // Clip toward zero by the outstanding penalty
  assign z_w = sx_q(s2_z);
  assign q_w = sx_q(s2_q);
  assign u_w = {{(WIDE_W-PEN_W){1'b0}}, s2_u};

  always_comb begin
    clip_raw = '0;
    if (s2_z > 32'sd0) begin
      clip_raw = z_w - u_w - q_w;
      if (clip_raw < 36'sd0) begin
        clip_raw = '0;
      end
    end else if (s2_z < 32'sd0) begin
      clip_raw = z_w + u_w - q_w;
      if (clip_raw > 36'sd0) begin
        clip_raw = '0;
      end
    end
  end

  assign nw_next = sat_q(clip_raw);
  assign nq_next = sat_q(q_w + sx_q(nw_next) - z_w);

  // Table write-back
  assign wr.en      = s2_valid && s2_in_range;
  assign wr.addr    = s2_addr;
  assign wr.weight  = nw_next;
  assign wr.penalty = nq_next;

  // Result registers; also the forwarding source for the write just made
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      wb_wr <= 1'b0;
    end else begin
      done  <= s2_valid;
      wb_wr <= s2_valid && s2_in_range;
    end
    wb_addr         <= s2_addr;
    new_weight      <= nw_next;
    applied_penalty <= nq_next;
  end

endmodule

`default_nettype wire

/* src/clwu_checker.sv */
// Port-level checker for the cumulative L1 weight update block, bound to the top level.
// Depends on cumulative_l1_weight_update_top_defines.svh.
`default_nettype none

`include "cumulative_l1_weight_update_top_defines.svh"

module clwu_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done
);

  // Every accepted transaction is returned with done
  `CLWU_ASSERT(a_result_follows, clk, rst, (start && !busy) |-> ##3 done, "result missing")

  // No result without an earlier accepted transaction
  `CLWU_ASSERT(a_no_spurious, clk, rst, done |-> $past(start && !busy, 3), "spurious result")

  // Reset starts the clearing sweep
  `CLWU_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> busy, "no clearing after reset")

  // Busy does not return right after the sweep ends; only reset restarts the sweep
  `CLWU_ASSERT(a_busy_once, clk, rst, $fell(busy) |=> !busy, "busy returned")

  // No result strobe while the tables are being cleared
  `CLWU_ASSERT(a_done_not_busy, clk, rst, done |-> !busy, "result during clearing")

endmodule

bind cumulative_l1_weight_update_top clwu_checker u_clwu_checker (.*);

`default_nettype wire

/* tb/clwu_result_checker.sv */
// Result checker for the cumulative L1 weight update block: predicts each update and
// compares it with what the block returns. Depends on clwu_pkg for widths and table depth.
module clwu_result_checker
  import clwu_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [IDX_W-1:0]        feature_index,
  input  wire logic signed [Q_W-1:0]   gradient,
  input  wire logic [LR_W-1:0]         step_size,
  input  wire logic [PEN_W-1:0]        total_penalty,
  input  wire logic                    done,
  input  wire logic signed [Q_W-1:0]   new_weight,
  input  wire logic signed [Q_W-1:0]   applied_penalty,
  output int                           mismatch_count,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_HI  = 64'sd2147483647;
  localparam longint Q_LO  = -64'sd2147483648;
  localparam longint HALF_LSB = 64'sd8388608;

  typedef struct {
    logic signed [Q_W-1:0] weight;
    logic signed [Q_W-1:0] penalty;
  } weight_update_t;

  // Model copies of the two tables
  logic signed [Q_W-1:0] weight_table  [NUM_FEATURES];
  logic signed [Q_W-1:0] penalty_table [NUM_FEATURES];

  // Updates predicted at acceptance, waiting for the block's result
  weight_update_t pending_updates[$];

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // Compute the clipped weight and updated applied penalty, and commit both
  function automatic weight_update_t apply_l1_update(
    input logic [IDX_W-1:0]      idx,
    input logic signed [Q_W-1:0] grad,
    input logic [LR_W-1:0]       rate,
    input logic [PEN_W-1:0]      pen
  );
    weight_update_t upd;
    longint w, q, g_v, lr_v, u, prod, z, nw, nq;
    bit in_range;
    in_range = int'(idx) < NUM_FEATURES;
    w = 0;
    q = 0;
    if (in_range) begin
      w = weight_table[idx];
      q = penalty_table[idx];
    end
    g_v  = grad;
    lr_v = rate;
    u    = pen;
    // Round the Q8.48 product to Q8.24, ties toward +infinity
    prod = (g_v * lr_v + HALF_LSB) >>> FRAC_W;
    z = clamp_q(w + prod);
    // Clip toward zero by the outstanding penalty
    if (z > 0) begin
      nw = z - (u + q);
      if (nw < 0) nw = 0;
    end else if (z < 0) begin
      nw = z + (u - q);
      if (nw > 0) nw = 0;
    end else begin
      nw = 0;
    end
    nw = clamp_q(nw);
    nq = clamp_q(q + (nw - z));
    if (in_range) begin
      weight_table[idx]  = nw[Q_W-1:0];
      penalty_table[idx] = nq[Q_W-1:0];
    end
    upd.weight  = nw[Q_W-1:0];
    upd.penalty = nq[Q_W-1:0];
    return upd;
  endfunction

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      weight_table[i]  = '0;
      penalty_table[i] = '0;
    end
  end

  // Compare returned results, then predict the transaction accepted at this edge
  always @(posedge clk) begin
    weight_update_t oldest;
    weight_update_t predicted;
    if (!rst) begin
      if (done) begin
        if (pending_updates.size() == 0) begin
          $error("result with nothing expected: new_weight %0d applied_penalty %0d",
                 new_weight, applied_penalty);
          mismatch_count++;
        end else begin
          oldest = pending_updates.pop_front();
          if (new_weight !== oldest.weight) begin
            $error("new_weight mismatch: expected %0d, actual %0d", oldest.weight, new_weight);
            mismatch_count++;
          end
          if (applied_penalty !== oldest.penalty) begin
            $error("applied_penalty mismatch: expected %0d, actual %0d",
                   oldest.penalty, applied_penalty);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_l1_update(feature_index, gradient, step_size, total_penalty);
        pending_updates = {pending_updates, predicted};
      end
    end
    outstanding <= pending_updates.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the cumulative L1 weight update block: clock, reset, stimulus, verdict.
// Depends on clwu_pkg, cumulative_l1_weight_update_top and clwu_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import clwu_pkg::*;

  localparam real CLK_PERIOD   = 4.0;
  localparam int  RESET_CYCLES = 12;
  localparam int  PHASE_ITEMS  = 120;
  localparam int  SETTLE_CYCLES = 8;
  localparam int  CYCLE_LIMIT  = 100000;

  localparam logic signed [Q_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] GRAD_MIN = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0] GRAD_ONE = 32'sh0100_0000;
  localparam logic [LR_W-1:0]       RATE_MAX = '1;
  localparam logic [LR_W-1:0]       RATE_HALF = 24'h80_0000;
  localparam logic [PEN_W-1:0]      PEN_MAX  = '1;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [IDX_W-1:0]       feature_index;
  logic signed [Q_W-1:0]  gradient;
  logic [LR_W-1:0]        step_size;
  logic [PEN_W-1:0]       total_penalty;
  logic                   done;
  logic signed [Q_W-1:0]  new_weight;
  logic signed [Q_W-1:0]  applied_penalty;
  int                     mismatch_count;
  int                     outstanding;
  int                     cycle_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  cumulative_l1_weight_update_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .feature_index   (feature_index),
    .gradient        (gradient),
    .step_size       (step_size),
    .total_penalty   (total_penalty),
    .done            (done),
    .new_weight      (new_weight),
    .applied_penalty (applied_penalty)
  );

  clwu_result_checker result_chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .feature_index   (feature_index),
    .gradient        (gradient),
    .step_size       (step_size),
    .total_penalty   (total_penalty),
    .done            (done),
    .new_weight      (new_weight),
    .applied_penalty (applied_penalty),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one transaction at a falling edge; return at the falling edge after acceptance
  task automatic send_update(input logic [IDX_W-1:0] idx, input logic signed [Q_W-1:0] grad,
                             input logic [LR_W-1:0] rate, input logic [PEN_W-1:0] pen);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    feature_index <= idx;
    gradient      <= grad;
    step_size     <= rate;
    total_penalty <= pen;
    @(negedge clk);
  endtask

  // Drop start for one cycle and scramble the idle payload
  task automatic idle_cycle();
    start         <= 1'b0;
    feature_index <= IDX_W'($urandom);
    gradient      <= $urandom;
    step_size     <= LR_W'($urandom);
    total_penalty <= PEN_W'($urandom);
    @(negedge clk);
  endtask

  // Hold off until every predicted result has come back
  task automatic drain_results();
    idle_cycle();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Random update biased toward a few hot features and moderate magnitudes
  task automatic send_random_update();
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] grad;
    logic [LR_W-1:0]       rate;
    logic [PEN_W-1:0]      pen;
    case ($urandom_range(3))
      0:       idx = IDX_W'($urandom_range(3));
      1:       idx = IDX_W'(1020 + $urandom_range(3));
      default: idx = IDX_W'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1, 2: grad = $urandom;
      8:       grad = '0;
      9:       grad = $urandom_range(1) ? GRAD_MAX : GRAD_MIN;
      default: grad = int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
    endcase
    case ($urandom_range(7))
      6:       rate = '0;
      7:       rate = RATE_MAX;
      default: rate = LR_W'($urandom);
    endcase
    case ($urandom_range(7))
      0, 1:    pen = PEN_W'($urandom);
      6:       pen = '0;
      7:       pen = PEN_MAX;
      default: pen = PEN_W'($urandom_range(32'h0200_0000));
    endcase
    send_update(idx, grad, rate, pen);
  endtask

  initial begin
    static int sender_idle_pct [4] = '{0, 62, 0, 32};
    rst           = 1'b1;
    start         = 1'b0;
    feature_index = '0;
    gradient      = '0;
    step_size     = '0;
    total_penalty = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero sum, rounding ties, both clip branches, saturation, back-to-back index
    send_update(10'd0, '0, '0, '0);
    send_update(10'd0, GRAD_ONE, RATE_HALF, '0);
    send_update(10'd0, GRAD_ONE, RATE_HALF, 31'h0040_0000);
    send_update(10'd0, -32'sh0400_0000, RATE_MAX, 31'h0010_0000);
    send_update(10'd1, 32'sd1, RATE_HALF, '0);
    send_update(10'd2, -32'sd1, RATE_HALF, '0);
    send_update(10'd3, -32'sd3, RATE_HALF, '0);
    send_update(10'd1023, GRAD_MAX, RATE_MAX, '0);
    send_update(10'd1023, GRAD_MAX, RATE_MAX, '0);
    send_update(10'd1023, GRAD_MIN, RATE_MAX, PEN_MAX);
    send_update(10'd1022, GRAD_MIN, RATE_MAX, '0);
    send_update(10'd1022, GRAD_MIN, RATE_MAX, '0);
    send_update(10'd1022, '0, '0, PEN_MAX);
    send_update(10'd4, GRAD_MAX, RATE_MAX, PEN_MAX);
    send_update(10'd4, GRAD_MAX, RATE_MAX, PEN_MAX);
    send_update(10'd4, GRAD_MIN, RATE_MAX, '0);
    send_update(10'd4, GRAD_MIN, RATE_MAX, PEN_MAX);
    send_update(10'd4, GRAD_MAX, RATE_MAX, '0);
    send_update(10'd5, GRAD_MIN, 24'h00_0001, PEN_MAX);
    send_update(10'd5, GRAD_MAX, 24'h00_0001, '0);
    send_update(10'd1023, '0, RATE_MAX, 31'h5555_5555);
    drain_results();

    // Random phases: no idling, heavy sender idling, no idling, light sender idling
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(99) < sender_idle_pct[phase]) idle_cycle();
        send_random_update();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
